### rtl/offset_ordered_reorder_buffer_macros.svh
// ----------------------------------------------------------------------------
// offset_ordered_reorder_buffer_macros.svh
// assertion macros for the reorder buffer, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef OFFSET_ORDERED_REORDER_BUFFER_MACROS_SVH
`define OFFSET_ORDERED_REORDER_BUFFER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define OORB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reorder buffer check failed");
// next-cycle implication
`define OORB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reorder buffer check failed");
`else
`define OORB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OORB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/oorb_pkg.sv
// ----------------------------------------------------------------------------
// oorb_pkg
// shared widths and item types of the offset ordered reorder buffer
// ----------------------------------------------------------------------------
package oorb_pkg;

  // field widths
  localparam int POS_W = 48;
  localparam int TAG_W = 16;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [TAG_W-1:0] tag_t;

  // finished job as it arrives
  typedef struct packed {
    pos_t start_position;
    pos_t end_position;
    tag_t job_tag;
  } in_item_t;

  // released or dropped job
  typedef struct packed {
    tag_t released_tag;
    pos_t released_start;
    pos_t released_end;
    logic dropped;
    logic last;
  } out_item_t;

endpackage

### rtl/oorb_inq.sv
// ----------------------------------------------------------------------------
// oorb_inq
// two-entry input queue between the input channel and the release engine
// ----------------------------------------------------------------------------
module oorb_inq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oorb_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output oorb_pkg::in_item_t q_item
);
  import oorb_pkg::*;

  in_item_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  // handshake
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = ent_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

### rtl/oorb_back.sv
// ----------------------------------------------------------------------------
// oorb_back
// slot store and in-order release engine with output register
// ----------------------------------------------------------------------------
module oorb_back #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  oorb_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output oorb_pkg::out_item_t out_item
);
  import oorb_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int MEM_W  = POS_W + TAG_W;

  // engine states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  pos_t                  exp_r;
  pos_t                  exp_nxt;
  logic [SLOT_COUNT-1:0] valid_r;
  pos_t                  start_r [SLOT_COUNT];
  logic [MEM_W-1:0]      mem [SLOT_COUNT];
  logic [MEM_W-1:0]      rd_data_r;
  tag_t                  pend_tag_r;
  pos_t                  pend_start_r;
  pos_t                  pend_end_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_item_r;

  logic                  in_match;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic                  hit_any;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  free_any;
  logic [SLOT_W-1:0]     free_idx;
  logic                  out_free;
  logic                  out_load;
  out_item_t             out_load_item;
  logic                  slot_wr;
  logic                  slot_clr;
  logic                  pend_from_in;
  logic                  pend_from_mem;
  pos_t                  rd_end;
  tag_t                  rd_tag;

  assign rd_end = rd_data_r[MEM_W-1:TAG_W];
  assign rd_tag = rd_data_r[TAG_W-1:0];

  // parallel compare of held starts against the expected position
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = valid_r[i] && (start_r[i] == exp_r);
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign in_match = (q_item.start_position == exp_r);
  assign out_free = !out_valid_r || !out_stall;

  // engine control
  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_load_item = '0;
    slot_wr       = 1'b0;
    slot_clr      = 1'b0;
    pend_from_in  = 1'b0;
    pend_from_mem = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (in_match) begin
            // in order: hold as pending, then look for followers
            q_pop        = 1'b1;
            pend_from_in = 1'b1;
            exp_nxt      = q_item.end_position;
            state_nxt    = S_SEARCH;
          end else if (free_any) begin
            q_pop   = 1'b1;
            slot_wr = 1'b1;
          end else if (out_free) begin
            // every slot taken: hand the job back marked dropped
            q_pop                        = 1'b1;
            out_load                     = 1'b1;
            out_load_item.released_tag   = q_item.job_tag;
            out_load_item.released_start = q_item.start_position;
            out_load_item.released_end   = q_item.end_position;
            out_load_item.dropped        = 1'b1;
            out_load_item.last           = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_load_item.released_tag   = pend_tag_r;
          out_load_item.released_start = pend_start_r;
          out_load_item.released_end   = pend_end_r;
          out_load_item.dropped        = 1'b0;
          out_load_item.last           = !hit_any;
          if (hit_any) begin
            slot_clr  = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        pend_from_mem = 1'b1;
        exp_nxt       = rd_end;
        state_nxt     = S_SEARCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
      if (slot_wr) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (slot_clr) begin
        valid_r[hit_idx] <= 1'b0;
      end
    end
  end

  // held starts, pending job and output payload
  always_ff @(posedge clk) begin
    if (slot_wr) begin
      start_r[free_idx] <= q_item.start_position;
    end
    if (pend_from_in) begin
      pend_tag_r   <= q_item.job_tag;
      pend_start_r <= q_item.start_position;
      pend_end_r   <= q_item.end_position;
    end else if (pend_from_mem) begin
      pend_tag_r   <= rd_tag;
      pend_start_r <= exp_r;
      pend_end_r   <= rd_end;
    end
    if (out_load) begin
      out_item_r <= out_load_item;
    end
  end

  // end and tag store, read at the matching slot
  always_ff @(posedge clk) begin
    if (slot_wr) begin
      mem[free_idx] <= {q_item.end_position, q_item.job_tag};
    end
    if (slot_clr) begin
      rd_data_r <= mem[hit_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/offset_ordered_reorder_buffer.sv
// ----------------------------------------------------------------------------
// offset_ordered_reorder_buffer
// releases finished jobs in trace order, holding early ones in slots
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall  | start, end position and tag
//  out_     | output    | out_valid/out_stall| released job, dropped, last
//
//  a held job goes to the lowest free slot, a dropped job to the output register;
//  a job released in order is held as pending, and each held job it frees takes
//  a compare step, then a store read step; no new job is taken until this ends
//  the input queue registers each job and buffers two while the engine is busy
//  synchronous active-low reset empties the queue, frees all slots and
//  sets the expected position to zero
//  out_stall holds the engine only when it has a result to hand over
// ----------------------------------------------------------------------------
`include "offset_ordered_reorder_buffer_macros.svh"

module offset_ordered_reorder_buffer #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oorb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output oorb_pkg::out_item_t out_item
);
  import oorb_pkg::*;

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  // front: input queue
  oorb_inq u_inq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: slot store and release engine
  oorb_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // checks
  `OORB_ASSERT_IMP(a_pop_needs_item, clk, rst_n, q_pop, q_valid)
  `OORB_ASSERT_IMP(a_full_queue_has_item, clk, rst_n, in_stall, q_valid)
  `OORB_ASSERT_IMP(a_drop_is_last, clk, rst_n, out_valid && out_item.dropped, out_item.last)
  `OORB_ASSERT_NXT(a_stall_keeps_result, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

### tb/sv/offset_ordered_reorder_buffer_tb.sv
// ----------------------------------------------------------------------------
// offset_ordered_reorder_buffer_tb
// in-order release of finished jobs, checked against a slot-level predictor
// ----------------------------------------------------------------------------
//  a short table of jobs covers in-order release, zero-length jobs, held jobs
//  with equal starts, cascades and the extremes of the position range; then
//  shuffled chains of contiguous jobs, stray jobs, floods that overrun every
//  slot and bridge jobs that empty the slots again, under three idle patterns
// ----------------------------------------------------------------------------
module offset_ordered_reorder_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oorb_pkg::*;

  localparam int SLOT_N = 32;
  localparam int RANDOM_JOBS = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam pos_t POS_MAX = '1;

  typedef struct packed {
    in_item_t  job;
    logic      typed;
    out_item_t want;
  } job_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int send_idle_pct = 34;
  int recv_stall_pct = 79;
  int fail_count = 0;
  int quiet_cycles = 0;
  int sent_jobs = 0;

  // shadow copy of the release position and the held slots
  pos_t      next_pos;
  logic      slot_busy [SLOT_N];
  pos_t      slot_from [SLOT_N];
  pos_t      slot_to [SLOT_N];
  tag_t      slot_tag [SLOT_N];
  out_item_t release_q [$];
  out_item_t step_q [$];
  out_item_t seen_want;

  // directed jobs, expected item typed in where it is obvious
  job_row_t job_table [13] = '{
    '{'{48'h0, 48'h10, 16'h0001}, 1'b1, '{16'h0001, 48'h0, 48'h10, 1'b0, 1'b1}},
    '{'{48'h10, 48'h10, 16'h0002}, 1'b1, '{16'h0002, 48'h10, 48'h10, 1'b0, 1'b1}},
    '{'{48'h30, 48'h40, 16'h0003}, 1'b0, '0},
    '{'{48'h30, 48'h50, 16'h0004}, 1'b0, '0},
    '{'{48'h20, 48'h30, 16'h0005}, 1'b0, '0},
    '{'{48'h10, 48'h20, 16'h0006}, 1'b0, '0},
    '{'{48'h40, 48'h30, 16'h0007}, 1'b0, '0},
    '{'{48'h50, POS_MAX, 16'hFFFF}, 1'b1, '{16'hFFFF, 48'h50, POS_MAX, 1'b0, 1'b1}},
    '{'{POS_MAX, 48'h0, 16'h0000}, 1'b1, '{16'h0000, POS_MAX, 48'h0, 1'b0, 1'b1}},
    '{'{POS_MAX, POS_MAX, 16'h5A5A}, 1'b0, '0},
    '{'{48'h0, 48'h1234, 16'hA5A5}, 1'b1, '{16'hA5A5, 48'h0, 48'h1234, 1'b0, 1'b1}},
    '{'{48'h1234, POS_MAX, 16'h0F0F}, 1'b0, '0},
    '{'{POS_MAX, 48'h0, 16'hF0F0}, 1'b1, '{16'hF0F0, POS_MAX, 48'h0, 1'b0, 1'b1}}
  };

  offset_ordered_reorder_buffer #(
    .SLOT_COUNT(SLOT_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // release order of one accepted job, results left in step_q
  function automatic void order_job(input in_item_t job);
    int        hit;
    out_item_t res;
    step_q.delete();
    if (job.start_position != next_pos) begin
      hit = -1;
      for (int i = SLOT_N - 1; i >= 0; i--) if (!slot_busy[i]) hit = i;
      if (hit >= 0) begin
        slot_busy[hit] = 1'b1;
        slot_from[hit] = job.start_position;
        slot_to[hit] = job.end_position;
        slot_tag[hit] = job.job_tag;
      end else begin
        step_q.push_back('{job.job_tag, job.start_position, job.end_position, 1'b1, 1'b1});
      end
      return;
    end
    step_q.push_back('{job.job_tag, job.start_position, job.end_position, 1'b0, 1'b0});
    next_pos = job.end_position;
    // cascade through held jobs, lowest slot first
    do begin
      hit = -1;
      for (int i = SLOT_N - 1; i >= 0; i--) begin
        if (slot_busy[i] && slot_from[i] == next_pos) hit = i;
      end
      if (hit >= 0) begin
        slot_busy[hit] = 1'b0;
        step_q.push_back('{slot_tag[hit], slot_from[hit], slot_to[hit], 1'b0, 1'b0});
        next_pos = slot_to[hit];
      end
    end while (hit >= 0);
    res = step_q.pop_back();
    res.last = 1'b1;
    step_q.push_back(res);
  endfunction

  function automatic pos_t any_pos();
    return pos_t'({$urandom, $urandom});
  endfunction

  // zero, short or arbitrary job length
  function automatic pos_t step_len();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick < 7) return pos_t'($urandom_range(64, 1));
    return any_pos();
  endfunction

  // present one item, hold it until taken, then predict its results
  task automatic send_job(input in_item_t job, input logic typed, input out_item_t want);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= job;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    order_job(job);
    if (typed) release_q.push_back(want);
    else foreach (step_q[i]) release_q.push_back(step_q[i]);
    sent_jobs++;
    @(negedge clk);
  endtask

  // contiguous jobs from the current position, mostly out of order
  task automatic send_chain(input int count);
    in_item_t jobs [$];
    in_item_t tmp;
    pos_t     at;
    int       j;
    at = next_pos;
    for (int i = 0; i < count; i++) begin
      tmp.start_position = at;
      at = at + step_len();
      tmp.end_position = at;
      tmp.job_tag = tag_t'($urandom);
      jobs.push_back(tmp);
      // now and then a second job with the same start
      if ($urandom_range(9) == 0) begin
        tmp.end_position = any_pos();
        tmp.job_tag = tag_t'($urandom);
        jobs.push_back(tmp);
      end
    end
    if ($urandom_range(4) != 0) begin
      for (int i = jobs.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = jobs[i];
        jobs[i] = jobs[j];
        jobs[j] = tmp;
      end
    end
    foreach (jobs[i]) send_job(jobs[i], 1'b0, '0);
  endtask

  // stray jobs that land in slots, or overrun them
  task automatic send_noise(input int count);
    in_item_t job;
    repeat (count) begin
      job = '{any_pos(), any_pos(), tag_t'($urandom)};
      send_job(job, 1'b0, '0);
    end
  endtask

  // bridge jobs from the current position to each held start until all free
  task automatic drain_slots();
    in_item_t job;
    int       low;
    do begin
      low = -1;
      for (int i = SLOT_N - 1; i >= 0; i--) if (slot_busy[i]) low = i;
      if (low >= 0) begin
        job = '{next_pos, slot_from[low], tag_t'($urandom)};
        send_job(job, 1'b0, '0);
      end
    end while (low >= 0);
  endtask

  // sender holds off until every expected item has come
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (release_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (release_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none, got %h", $time, out_item);
      end else begin
        seen_want = release_q.pop_front();
        check_field("released_tag", seen_want.released_tag, out_item.released_tag);
        check_field("released_start", seen_want.released_start, out_item.released_start);
        check_field("released_end", seen_want.released_end, out_item.released_end);
        check_field("dropped", seen_want.dropped, out_item.dropped);
        check_field("last", seen_want.last, out_item.last);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin
    int pick;
    int held;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    next_pos = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed jobs
    foreach (job_table[i]) send_job(job_table[i].job, job_table[i].typed, job_table[i].want);
    wait_idle();

    // random jobs under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      send_noise($urandom_range(36, 33));
      while (sent_jobs < $size(job_table) + (phase + 1) * RANDOM_JOBS / 3) begin
        pick = $urandom_range(19);
        if (pick < 14) begin
          send_chain(($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1));
        end else if (pick < 17) begin
          send_noise($urandom_range(4, 1));
        end else begin
          send_noise($urandom_range(36, 33));
        end
        held = 0;
        foreach (slot_busy[i]) held += slot_busy[i];
        if (held > 16 || $urandom_range(2) == 0) drain_slots();
        if ($urandom_range(7) == 0) wait_idle();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && release_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/oorb_pkg.sv
rtl/oorb_inq.sv
rtl/oorb_back.sv
rtl/offset_ordered_reorder_buffer.sv
tb/sv/offset_ordered_reorder_buffer_tb.sv
